/* rtl/hsf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsf_pkg
// shared constants, node sign table and shift codes of the hex20 shape unit
// ----------------------------------------------------------------------------
package hsf_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int NODE_COUNT = 20;
	localparam int NODE_W     = 5;
	localparam int OQ_DEPTH   = 8;
	localparam int STAGES     = 5;

	localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODE_COUNT - 1);

	// sign of a node's reference coordinate on one axis
	typedef logic [1:0] sgn_t;
	localparam sgn_t SGN_ZERO = 2'd0;
	localparam sgn_t SGN_POS  = 2'd1;
	localparam sgn_t SGN_NEG  = 2'd2;

	// one sign per axis, index 0 = xi, 1 = eta, 2 = zeta
	typedef sgn_t [2:0] node_sgn_t;

	// final scaling of a four-factor product, in powers of two
	typedef enum logic [2:0] {
		SH_3F3,  // corner shape: divide by 8 * S^3
		SH_2F3,  // corner derivative: divide by 8 * S^2
		SH_3F2,  // midside shape: divide by 4 * S^3
		SH_2F2,  // midside derivative along a nonzero axis: divide by 4 * S^2
		SH_2F1   // midside derivative along the zero axis: divide by 2 * S^2
	} shift_code_t;

	function automatic node_sgn_t node_signs(input logic [NODE_W-1:0] n);
		node_sgn_t s;
		case (n)
			5'd0:    s = {SGN_NEG,  SGN_NEG,  SGN_NEG};
			5'd1:    s = {SGN_NEG,  SGN_NEG,  SGN_POS};
			5'd2:    s = {SGN_NEG,  SGN_POS,  SGN_POS};
			5'd3:    s = {SGN_NEG,  SGN_POS,  SGN_NEG};
			5'd4:    s = {SGN_POS,  SGN_NEG,  SGN_NEG};
			5'd5:    s = {SGN_POS,  SGN_NEG,  SGN_POS};
			5'd6:    s = {SGN_POS,  SGN_POS,  SGN_POS};
			5'd7:    s = {SGN_POS,  SGN_POS,  SGN_NEG};
			5'd8:    s = {SGN_NEG,  SGN_NEG,  SGN_ZERO};
			5'd9:    s = {SGN_NEG,  SGN_ZERO, SGN_NEG};
			5'd10:   s = {SGN_ZERO, SGN_NEG,  SGN_NEG};
			5'd11:   s = {SGN_NEG,  SGN_ZERO, SGN_POS};
			5'd12:   s = {SGN_ZERO, SGN_NEG,  SGN_POS};
			5'd13:   s = {SGN_NEG,  SGN_POS,  SGN_ZERO};
			5'd14:   s = {SGN_ZERO, SGN_POS,  SGN_POS};
			5'd15:   s = {SGN_ZERO, SGN_POS,  SGN_NEG};
			5'd16:   s = {SGN_POS,  SGN_NEG,  SGN_ZERO};
			5'd17:   s = {SGN_POS,  SGN_ZERO, SGN_NEG};
			5'd18:   s = {SGN_POS,  SGN_ZERO, SGN_POS};
			5'd19:   s = {SGN_POS,  SGN_POS,  SGN_ZERO};
			default: s = {SGN_ZERO, SGN_ZERO, SGN_ZERO};
		endcase
		return s;
	endfunction

endpackage

/* rtl/hsf_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsf_front
// accepts points, clamps each coordinate to [-1,1], two-entry point queue
// ----------------------------------------------------------------------------
module hsf_front #(
	parameter int FRAC_BITS = hsf_pkg::FRAC_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic signed [FRAC_BITS+1:0] coord_xi,
	input  logic signed [FRAC_BITS+1:0] coord_eta,
	input  logic signed [FRAC_BITS+1:0] coord_zeta,
	output logic                        head_valid,
	input  logic                        head_pop,
	output logic signed [FRAC_BITS+1:0] head_c [3]
);

	localparam int CW = FRAC_BITS + 2;
	localparam logic signed [CW-1:0] ONE  = CW'(1) << FRAC_BITS;
	localparam logic signed [CW-1:0] MONE = -ONE;

	logic signed [CW-1:0] pt_q [2][3];
	logic                 wr_ptr_q;
	logic                 rd_ptr_q;
	logic [1:0]           cnt_q;
	logic signed [CW-1:0] raw [3];
	logic signed [CW-1:0] sat [3];
	logic                 wr_en;
	logic                 rd_en;

	assign raw[0] = coord_xi;
	assign raw[1] = coord_eta;
	assign raw[2] = coord_zeta;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (raw[i] > ONE)
				sat[i] = ONE;
			else if (raw[i] < MONE)
				sat[i] = MONE;
			else
				sat[i] = raw[i];
		end
	end

	assign full       = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign wr_en      = push && !full;
	assign rd_en      = head_pop && head_valid;

	always_comb begin
		for (int i = 0; i < 3; i++)
			head_c[i] = pt_q[rd_ptr_q][i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr_en)
				wr_ptr_q <= !wr_ptr_q;
			if (rd_en)
				rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + 2'(wr_en) - 2'(rd_en);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			for (int i = 0; i < 3; i++)
				pt_q[wr_ptr_q][i] <= sat[i];
		end
	end

endmodule

/* rtl/hsf_out_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsf_out_fifo
// result word queue, head shown while not empty
// ----------------------------------------------------------------------------
module hsf_out_fifo #(
	parameter int W     = 82,
	parameter int DEPTH = hsf_pkg::OQ_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [W-1:0]               wr_data,
	input  logic                       rd_en,
	output logic [W-1:0]               rd_data,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_rd;

	assign empty   = (cnt_q == '0);
	assign count   = cnt_q;
	assign rd_data = mem_q[rd_ptr_q];
	assign do_rd   = rd_en && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			cnt_q <= cnt_q + CW'(wr_en) - CW'(do_rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

/* rtl/hsf_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsf_back
// node sequencer and five-stage product pipeline, four lanes per node
// ----------------------------------------------------------------------------
module hsf_back #(
	parameter int FRAC_BITS = hsf_pkg::FRAC_BITS,
	parameter int DEPTH     = hsf_pkg::OQ_DEPTH
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    head_valid,
	output logic                                    head_pop,
	input  logic signed [FRAC_BITS+1:0]             head_c [3],
	input  logic [$clog2(DEPTH+1)-1:0]              oq_count,
	output logic                                    oq_wr,
	output logic [hsf_pkg::NODE_W+4*(FRAC_BITS+3):0] oq_data
);

	localparam int NW  = hsf_pkg::NODE_W;
	localparam int CW  = FRAC_BITS + 2;
	localparam int SW  = FRAC_BITS + 4;
	localparam int MW  = FRAC_BITS + 3;
	localparam int PW  = 4 * MW;
	localparam int RW  = PW + 1;
	localparam int OW  = FRAC_BITS + 3;
	localparam int QW  = $clog2(DEPTH + 1) + 1;
	localparam int K3F3 = 3 * FRAC_BITS + 3;
	localparam int K2F3 = 2 * FRAC_BITS + 3;
	localparam int K3F2 = 3 * FRAC_BITS + 2;
	localparam int K2F2 = 2 * FRAC_BITS + 2;
	localparam int K2F1 = 2 * FRAC_BITS + 1;

	localparam logic signed [SW-1:0] ONE  = SW'(1) << FRAC_BITS;
	localparam logic signed [SW-1:0] TWO  = SW'(2) << FRAC_BITS;
	localparam logic signed [SW-1:0] UNIT = SW'(1);
	localparam logic [RW-1:0] LIM   = RW'(1) << (FRAC_BITS + 2);
	localparam logic [RW-1:0] LIMM1 = LIM - RW'(1);

	// issue control
	logic [NW-1:0] node_q;
	logic          issue;

	// factor build
	hsf_pkg::node_sgn_t   sg;
	logic signed [SW-1:0] c  [3];
	logic signed [SW-1:0] sc [3];
	logic signed [SW-1:0] sv [3];
	logic signed [SW-1:0] t  [3];
	logic signed [SW-1:0] sum_c, a_v, b_v, cm, ta, tb;
	logic signed [SW-1:0] f  [4][4];
	logic                 mid;
	logic                 got;
	logic [1:0]           m_idx;
	logic [1:0]           na;
	hsf_pkg::shift_code_t sh [4];
	logic [MW-1:0]        mg [4][4];
	logic                 ng [4];

	// pipeline
	logic [hsf_pkg::STAGES-1:0] v_q;
	logic [NW-1:0]        node_s1, node_s2, node_s3, node_s4, node_s5;
	logic [MW-1:0]        mag_s1 [4][4];
	logic                 neg_s1 [4], neg_s2 [4], neg_s3 [4], neg_s4 [4];
	hsf_pkg::shift_code_t sh_s1 [4], sh_s2 [4], sh_s3 [4], sh_s4 [4];
	logic [2*MW-1:0]      p_s2 [4], q_s2 [4];
	logic [2*MW-1:0]      ll_s3 [4], lh_s3 [4], hl_s3 [4], hh_s3 [4];
	logic [PW-1:0]        prod_s4 [4];
	logic [OW-1:0]        val_s5 [4];
	logic [OW-1:0]        val_n [4];

	// issue one node a cycle while the result queue has room for all in flight
	assign issue    = head_valid &&
	                  ((QW'(oq_count) + QW'($countones(v_q))) < QW'(DEPTH));
	assign head_pop = issue && (node_q == hsf_pkg::LAST_NODE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_q <= '0;
			v_q    <= '0;
		end else begin
			if (issue)
				node_q <= (node_q == hsf_pkg::LAST_NODE) ? '0 : node_q + 1'b1;
			v_q <= {v_q[hsf_pkg::STAGES-2:0], issue};
		end
	end

	always_comb begin
		sg    = hsf_pkg::node_signs(node_q);
		mid   = 1'b0;
		m_idx = 2'd0;
		got   = 1'b0;
		na    = 2'd0;
		ta    = ONE;
		tb    = ONE;
		for (int i = 0; i < 3; i++) begin
			c[i] = SW'(head_c[i]);
			case (sg[i])
				hsf_pkg::SGN_POS: begin
					sc[i] = c[i];
					sv[i] = UNIT;
				end
				hsf_pkg::SGN_NEG: begin
					sc[i] = -c[i];
					sv[i] = -UNIT;
				end
				default: begin
					sc[i] = '0;
					sv[i] = '0;
				end
			endcase
			t[i] = ONE + sc[i];
			if (sg[i] == hsf_pkg::SGN_ZERO) begin
				mid   = 1'b1;
				m_idx = 2'(i);
			end
		end
		cm    = c[m_idx];
		a_v   = ONE - cm;
		b_v   = ONE + cm;
		sum_c = sc[0] + sc[1] + sc[2] - TWO;
		// the two axes other than the zero axis of a midside node
		for (int i = 0; i < 3; i++) begin
			if (2'(i) != m_idx) begin
				if (!got) begin
					ta  = t[i];
					na  = 2'(i);
					got = 1'b1;
				end else begin
					tb = t[i];
				end
			end
		end
		if (!mid) begin
			f[0][0] = t[0];
			f[0][1] = t[1];
			f[0][2] = t[2];
			f[0][3] = sum_c;
			sh[0]   = hsf_pkg::SH_3F3;
			for (int i = 0; i < 3; i++) begin
				f[1+i][0] = sv[i];
				f[1+i][1] = t[(i+1)%3];
				f[1+i][2] = t[(i+2)%3];
				f[1+i][3] = sum_c + t[i];
				sh[1+i]   = hsf_pkg::SH_2F3;
			end
		end else begin
			f[0][0] = a_v;
			f[0][1] = b_v;
			f[0][2] = ta;
			f[0][3] = tb;
			sh[0]   = hsf_pkg::SH_3F2;
			for (int i = 0; i < 3; i++) begin
				if (2'(i) == m_idx) begin
					f[1+i][0] = -cm;
					f[1+i][1] = ta;
					f[1+i][2] = tb;
					f[1+i][3] = UNIT;
					sh[1+i]   = hsf_pkg::SH_2F1;
				end else begin
					f[1+i][0] = sv[i];
					f[1+i][1] = a_v;
					f[1+i][2] = b_v;
					f[1+i][3] = (2'(i) == na) ? tb : ta;
					sh[1+i]   = hsf_pkg::SH_2F2;
				end
			end
		end
		// sign and magnitude per lane
		for (int l = 0; l < 4; l++) begin
			ng[l] = 1'b0;
			for (int j = 0; j < 4; j++) begin
				ng[l]    = ng[l] ^ f[l][j][SW-1];
				mg[l][j] = f[l][j][SW-1] ? MW'(-f[l][j]) : MW'(f[l][j]);
			end
		end
	end

	// round to nearest with ties away from zero, then clamp
	always_comb begin
		logic [RW-1:0] rnd;
		logic [RW-1:0] r;
		for (int l = 0; l < 4; l++) begin
			case (sh_s4[l])
				hsf_pkg::SH_3F3: begin
					rnd = RW'(prod_s4[l]) + (RW'(1) << (K3F3 - 1));
					r   = rnd >> K3F3;
				end
				hsf_pkg::SH_2F3: begin
					rnd = RW'(prod_s4[l]) + (RW'(1) << (K2F3 - 1));
					r   = rnd >> K2F3;
				end
				hsf_pkg::SH_3F2: begin
					rnd = RW'(prod_s4[l]) + (RW'(1) << (K3F2 - 1));
					r   = rnd >> K3F2;
				end
				hsf_pkg::SH_2F2: begin
					rnd = RW'(prod_s4[l]) + (RW'(1) << (K2F2 - 1));
					r   = rnd >> K2F2;
				end
				default: begin
					rnd = RW'(prod_s4[l]) + (RW'(1) << (K2F1 - 1));
					r   = rnd >> K2F1;
				end
			endcase
			if (neg_s4[l]) begin
				if (r > LIM)
					r = LIM;
				val_n[l] = OW'(-r);
			end else begin
				if (r > LIMM1)
					r = LIMM1;
				val_n[l] = OW'(r);
			end
		end
	end

	always_ff @(posedge clk) begin
		node_s1 <= node_q;
		node_s2 <= node_s1;
		node_s3 <= node_s2;
		node_s4 <= node_s3;
		node_s5 <= node_s4;
		for (int l = 0; l < 4; l++) begin
			for (int j = 0; j < 4; j++)
				mag_s1[l][j] <= mg[l][j];
			neg_s1[l] <= ng[l];
			sh_s1[l]  <= sh[l];
			// pair products
			p_s2[l]   <= (2*MW)'(mag_s1[l][0]) * (2*MW)'(mag_s1[l][1]);
			q_s2[l]   <= (2*MW)'(mag_s1[l][2]) * (2*MW)'(mag_s1[l][3]);
			neg_s2[l] <= neg_s1[l];
			sh_s2[l]  <= sh_s1[l];
			// partial products of the wide multiply
			ll_s3[l]  <= (2*MW)'(p_s2[l][MW-1:0])    * (2*MW)'(q_s2[l][MW-1:0]);
			lh_s3[l]  <= (2*MW)'(p_s2[l][MW-1:0])    * (2*MW)'(q_s2[l][2*MW-1:MW]);
			hl_s3[l]  <= (2*MW)'(p_s2[l][2*MW-1:MW]) * (2*MW)'(q_s2[l][MW-1:0]);
			hh_s3[l]  <= (2*MW)'(p_s2[l][2*MW-1:MW]) * (2*MW)'(q_s2[l][2*MW-1:MW]);
			neg_s3[l] <= neg_s2[l];
			sh_s3[l]  <= sh_s2[l];
			prod_s4[l] <= {hh_s3[l], ll_s3[l]} +
			              ((PW'(lh_s3[l]) + PW'(hl_s3[l])) << MW);
			neg_s4[l] <= neg_s3[l];
			sh_s4[l]  <= sh_s3[l];
			val_s5[l] <= val_n[l];
		end
	end

	assign oq_wr   = v_q[hsf_pkg::STAGES-1];
	assign oq_data = {node_s5, val_s5[0], val_s5[1], val_s5[2], val_s5[3],
	                  (node_s5 == hsf_pkg::LAST_NODE)};

endmodule

/* rtl/hex20_shape_function_eval_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex20_shape_function_eval_unit
// 20-node serendipity hexahedron shape functions and derivatives at a point
// ----------------------------------------------------------------------------
// usage:
//   input side is a queue: drive coord_xi/eta/zeta and raise push; a word is
//   taken on a clock edge with push high and full low. coordinates are
//   clamped to [-1,1] (FRAC_BITS fraction bits) when taken.
//   output side is a queue: while empty is low the oldest result word is on
//   node_index, shape_value, deriv_*, last_node; raise pop to take it.
//   every point yields twenty words, nodes 0 to 19 in order, last_node on 19.
// timing:
//   the back end issues one node per cycle while the result queue has room,
//   driven by the single node sequencer, and each word passes through the
//   product pipeline before it enters the result queue. the front holds two
//   points, the one being worked on and one waiting, so a second point is
//   taken at once and full then stays high until node 19 of the current
//   point is issued.
// reset and stall:
//   arst_n empties both queues. if pop stays low the result queue fills,
//   the node sequencer holds, then the point queue fills and full rises.
// ----------------------------------------------------------------------------
module hex20_shape_function_eval_unit #(
	parameter int FRAC_BITS = hsf_pkg::FRAC_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  logic signed [FRAC_BITS+1:0]          coord_xi,
	input  logic signed [FRAC_BITS+1:0]          coord_eta,
	input  logic signed [FRAC_BITS+1:0]          coord_zeta,
	output logic                                 empty,
	input  logic                                 pop,
	output logic [hsf_pkg::NODE_W-1:0]           node_index,
	output logic signed [FRAC_BITS+2:0]          shape_value,
	output logic signed [FRAC_BITS+2:0]          deriv_xi,
	output logic signed [FRAC_BITS+2:0]          deriv_eta,
	output logic signed [FRAC_BITS+2:0]          deriv_zeta,
	output logic                                 last_node
);

	localparam int OW    = FRAC_BITS + 3;
	localparam int NW    = hsf_pkg::NODE_W;
	localparam int WW    = NW + 4 * OW + 1;
	localparam int DEPTH = hsf_pkg::OQ_DEPTH;

	// front to back point handoff
	logic                        head_valid;
	logic                        head_pop;
	logic signed [FRAC_BITS+1:0] head_c [3];

	// back to result queue
	logic                        oq_wr;
	logic [WW-1:0]               oq_data;
	logic [WW-1:0]               rd_word;
	logic [$clog2(DEPTH+1)-1:0]  oq_count;

	hsf_front #(
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.coord_xi   (coord_xi),
		.coord_eta  (coord_eta),
		.coord_zeta (coord_zeta),
		.head_valid (head_valid),
		.head_pop   (head_pop),
		.head_c     (head_c)
	);

	hsf_back #(
		.FRAC_BITS (FRAC_BITS),
		.DEPTH     (DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_pop   (head_pop),
		.head_c     (head_c),
		.oq_count   (oq_count),
		.oq_wr      (oq_wr),
		.oq_data    (oq_data)
	);

	// result queue, sized so the sequencer never overruns it
	hsf_out_fifo #(
		.W     (WW),
		.DEPTH (DEPTH)
	) u_out_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (oq_wr),
		.wr_data (oq_data),
		.rd_en   (pop),
		.rd_data (rd_word),
		.empty   (empty),
		.count   (oq_count)
	);

	// unpack the head word: node, shape, d/dxi, d/deta, d/dzeta, last flag
	assign node_index  = rd_word[WW-1 -: NW];
	assign shape_value = rd_word[4*OW -: OW];
	assign deriv_xi    = rd_word[3*OW -: OW];
	assign deriv_eta   = rd_word[2*OW -: OW];
	assign deriv_zeta  = rd_word[OW -: OW];
	assign last_node   = rd_word[0];

endmodule

/* rtl/hsf_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsf_checker
// port-level checks of last flag, node range, result order and head stability
// ----------------------------------------------------------------------------
module hsf_checker #(
	parameter int FRAC_BITS = hsf_pkg::FRAC_BITS
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        push,
	input logic                        full,
	input logic signed [FRAC_BITS+1:0] coord_xi,
	input logic signed [FRAC_BITS+1:0] coord_eta,
	input logic signed [FRAC_BITS+1:0] coord_zeta,
	input logic                        empty,
	input logic                        pop,
	input logic [hsf_pkg::NODE_W-1:0]  node_index,
	input logic signed [FRAC_BITS+2:0] shape_value,
	input logic signed [FRAC_BITS+2:0] deriv_xi,
	input logic signed [FRAC_BITS+2:0] deriv_eta,
	input logic signed [FRAC_BITS+2:0] deriv_zeta,
	input logic                        last_node
);

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (last_node == (node_index == hsf_pkg::LAST_NODE)))
		else $error("last_node does not match node 19");

	a_node_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (node_index <= hsf_pkg::LAST_NODE))
		else $error("node_index out of range");

	a_node_order: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && !last_node) |=>
			(empty || (node_index == $past(node_index) + 1'b1)))
		else $error("result words out of node order");

	a_head_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=>
			(!empty && $stable(node_index) && $stable(shape_value) &&
			 $stable(deriv_xi)))
		else $error("result head changed while not taken");

endmodule

bind hex20_shape_function_eval_unit hsf_checker #(.FRAC_BITS(FRAC_BITS)) u_hsf_checker (.*);

/* tb/tb_hex20_shape_function_eval_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hex20_shape_function_eval_unit
// self-checking bench for the hex20 shape function unit
// ----------------------------------------------------------------------------
// points go in through the push/full queue, twenty node words per point come
// out through the empty/pop queue. an independent fixed-point predictor works
// out every node word at full precision and a checker compares each popped
// word, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_hex20_shape_function_eval_unit;

	localparam int FB = hsf_pkg::FRAC_BITS;
	localparam int IW = FB + 2;
	localparam int OW = FB + 3;
	localparam int NW = hsf_pkg::NODE_W;
	localparam longint ONE = 64'sd1 <<< FB;

	typedef struct packed {
		logic [NW-1:0] node;
		logic [OW-1:0] val;
		logic [OW-1:0] dxi;
		logic [OW-1:0] deta;
		logic [OW-1:0] dzeta;
		logic last;
	} node_word_t;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	logic signed [IW-1:0] coord_xi;
	logic signed [IW-1:0] coord_eta;
	logic signed [IW-1:0] coord_zeta;
	logic empty;
	logic pop;
	logic [NW-1:0] node_index;
	logic signed [OW-1:0] shape_value;
	logic signed [OW-1:0] deriv_xi;
	logic signed [OW-1:0] deriv_eta;
	logic signed [OW-1:0] deriv_zeta;
	logic last_node;

	node_word_t expected_words[$];
	int error_count = 0;
	// sender and receiver idle rates, in percent
	int push_idle_pct = 16;
	int pop_idle_pct = 16;
	// long receiver hold-off, in cycles, counted by the pop process
	int pop_hold_cycles = 0;

	hex20_shape_function_eval_unit i_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.coord_xi(coord_xi), .coord_eta(coord_eta), .coord_zeta(coord_zeta),
		.empty(empty), .pop(pop), .node_index(node_index),
		.shape_value(shape_value), .deriv_xi(deriv_xi), .deriv_eta(deriv_eta),
		.deriv_zeta(deriv_zeta), .last_node(last_node)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// node reference position on each axis: -1, 0 or +1
	function automatic int axis_sign(input int n, input int ax);
		int tbl[20][3] = '{
			'{-1, -1, -1}, '{ 1, -1, -1}, '{ 1,  1, -1}, '{-1,  1, -1},
			'{-1, -1,  1}, '{ 1, -1,  1}, '{ 1,  1,  1}, '{-1,  1,  1},
			'{ 0, -1, -1}, '{-1,  0, -1}, '{-1, -1,  0}, '{ 1,  0, -1},
			'{ 1, -1,  0}, '{ 0,  1, -1}, '{ 1,  1,  0}, '{-1,  1,  0},
			'{ 0, -1,  1}, '{-1,  0,  1}, '{ 1,  0,  1}, '{ 0,  1,  1}};
		return tbl[n][ax];
	endfunction

	// exact four-factor product scaled down by 2^k, rounded half away from zero
	function automatic logic [OW-1:0] scaled_product(input longint f0, input longint f1,
			input longint f2, input longint f3, input int k);
		logic signed [135:0] p;
		logic [135:0] m;
		logic neg;
		logic [135:0] r;
		p = 136'(f0) * 136'(f1) * 136'(f2) * 136'(f3);
		neg = p[135];
		m = neg ? -p : p;
		r = (m + (136'd1 << (k - 1))) >> k;
		if (neg) begin
			if (r > (136'd1 << (FB + 2))) r = 136'd1 << (FB + 2);
			return OW'(-r);
		end
		if (r > (136'd1 << (FB + 2)) - 1) r = (136'd1 << (FB + 2)) - 1;
		return OW'(r);
	endfunction

	function automatic longint clamp_coord(input logic signed [IW-1:0] raw);
		longint v;
		v = raw;
		if (v > ONE) v = ONE;
		if (v < -ONE) v = -ONE;
		return v;
	endfunction

	// queue the twenty node words that a point produces
	task automatic predict_node_words(input logic signed [IW-1:0] xi,
			input logic signed [IW-1:0] eta, input logic signed [IW-1:0] zeta);
		longint c[3];
		longint s[3];
		longint t[3];
		logic [OW-1:0] v[4];
		longint sum, a, b;
		int m, j, k;
		node_word_t w;
		c[0] = clamp_coord(xi);
		c[1] = clamp_coord(eta);
		c[2] = clamp_coord(zeta);
		for (int n = 0; n < hsf_pkg::NODE_COUNT; n++) begin
			m = -1;
			for (int i = 0; i < 3; i++) begin
				s[i] = axis_sign(n, i);
				t[i] = ONE + s[i] * c[i];
				if (s[i] == 0) m = i;
			end
			if (m < 0) begin
				// corner node
				sum = s[0] * c[0] + s[1] * c[1] + s[2] * c[2] - 2 * ONE;
				v[0] = scaled_product(t[0], t[1], t[2], sum, 3 * FB + 3);
				for (int i = 0; i < 3; i++) begin
					j = (i + 1) % 3;
					k = (i + 2) % 3;
					v[1 + i] = scaled_product(s[i], t[j], t[k], sum + t[i], 2 * FB + 3);
				end
			end else begin
				// midside node, zero on axis m
				j = (m + 1) % 3;
				k = (m + 2) % 3;
				a = ONE - c[m];
				b = ONE + c[m];
				v[0] = scaled_product(a, b, t[j], t[k], 3 * FB + 2);
				v[1 + m] = scaled_product(-c[m], t[j], t[k], 1, 2 * FB + 1);
				v[1 + j] = scaled_product(s[j], a, b, t[k], 2 * FB + 2);
				v[1 + k] = scaled_product(s[k], a, b, t[j], 2 * FB + 2);
			end
			w.node = NW'(n);
			w.val = v[0];
			w.dxi = v[1];
			w.deta = v[2];
			w.dzeta = v[3];
			w.last = (n == hsf_pkg::NODE_COUNT - 1);
			expected_words.push_back(w);
		end
	endtask

	task automatic report_mismatch(input string what, input logic [OW-1:0] got,
			input logic [OW-1:0] want, input logic [NW-1:0] node);
		$display("mismatch node %0d %s: got %0h expected %0h", node, what, got, want);
		error_count++;
	endtask

	// offer one point and hold it until the unit takes it
	task automatic send_point(input logic signed [IW-1:0] xi,
			input logic signed [IW-1:0] eta, input logic signed [IW-1:0] zeta);
		while ($urandom_range(99) < push_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		coord_xi <= xi;
		coord_eta <= eta;
		coord_zeta <= zeta;
		@(posedge clk);
		while (full) @(posedge clk);
		predict_node_words(xi, eta, zeta);
	endtask

	// stop offering and wait until every predicted word has been taken
	task automatic wait_drained;
		push <= 1'b0;
		@(posedge clk);
		while (expected_words.size() != 0) @(posedge clk);
	endtask

	// random coordinate: mostly in range, sometimes anywhere in the 18-bit field
	function automatic logic signed [IW-1:0] rand_coord;
		case ($urandom_range(9))
			0: return IW'($urandom);
			1: return ($urandom_range(1)) ? IW'(ONE) : IW'(-ONE);
			2: return IW'(0);
			default: return IW'(longint'($urandom_range(2 * ONE)) - ONE);
		endcase
	endfunction

	// receiver: pops at random, or holds off while a hold count is pending
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop_hold_cycles > 0) begin
				pop_hold_cycles <= pop_hold_cycles - 1;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= pop_idle_pct);
			end
		end
	end

	// checker: compare each taken word with the oldest prediction
	always @(posedge clk) begin
		node_word_t w;
		if (arst_n && pop && !empty) begin
			if (expected_words.size() == 0) begin
				$display("unexpected word node %0d", node_index);
				error_count++;
			end else begin
				w = expected_words.pop_front();
				if (node_index !== w.node) report_mismatch("node", OW'(node_index), OW'(w.node), w.node);
				if (shape_value !== w.val) report_mismatch("shape", shape_value, w.val, w.node);
				if (deriv_xi !== w.dxi) report_mismatch("d_xi", deriv_xi, w.dxi, w.node);
				if (deriv_eta !== w.deta) report_mismatch("d_eta", deriv_eta, w.deta, w.node);
				if (deriv_zeta !== w.dzeta) report_mismatch("d_zeta", deriv_zeta, w.dzeta, w.node);
				if (last_node !== w.last) report_mismatch("last", OW'(last_node), OW'(w.last), w.node);
			end
		end
	end

	// corners, centre, face centres, clamping and field extremes
	task automatic test_directed_points;
		send_point(-IW'(ONE), -IW'(ONE), -IW'(ONE));
		send_point(IW'(ONE), IW'(ONE), IW'(ONE));
		send_point(IW'(ONE), -IW'(ONE), IW'(ONE));
		send_point(0, 0, 0);
		send_point(IW'(ONE), 0, 0);
		send_point(0, -IW'(ONE), 0);
		send_point(0, 0, IW'(ONE));
		// out of range, clamped to plus or minus one
		send_point({1'b0, {(IW-1){1'b1}}}, {1'b1, {(IW-1){1'b0}}}, IW'(ONE + 1));
		send_point(IW'(-ONE - 1), {1'b0, {(IW-1){1'b1}}}, {1'b1, {(IW-1){1'b0}}});
		send_point(IW'(-1), IW'(1), IW'(-1));
		send_point(IW'(ONE / 2), IW'(-ONE / 2), IW'(ONE / 3));
		send_point(IW'(ONE - 1), IW'(-ONE + 1), IW'(1));
		wait_drained;
	endtask

	// receiver holds off long enough for both queues to fill and full to rise
	task automatic test_back_pressure;
		pop_hold_cycles = 400;
		repeat (8) send_point(rand_coord(), rand_coord(), rand_coord());
		wait_drained;
	endtask

	// random points, with a stretch without idling on either side
	task automatic test_random_points;
		for (int i = 0; i < 350; i++) begin
			if (i == 100) begin
				push_idle_pct = 0;
				pop_idle_pct = 0;
			end
			if (i == 180) begin
				push_idle_pct = 16;
				pop_idle_pct = 16;
			end
			// sender pause until everything has come out
			if (i == 250) wait_drained;
			send_point(rand_coord(), rand_coord(), rand_coord());
		end
		wait_drained;
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		coord_xi = '0;
		coord_eta = '0;
		coord_zeta = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_points;
		test_back_pressure;
		test_random_points;
		repeat (50) @(posedge clk);
		if (error_count == 0 && expected_words.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
